/* rtl/mdf_pkg.sv */
`default_nettype none

package mdf_pkg;

    // field widths fixed by the frame format
    localparam int SEQ_W  = 64;
    localparam int SIZE_W = 16;
    localparam int FLOW_IN_W = 4;

    // footer carrying the sequence number, stripped on delivery
    localparam logic [SIZE_W-1:0] FOOTER_BYTES = 16'd32;

    // result verdict codes
    typedef enum logic [1:0] {
        VERDICT_ERROR   = 2'd0,
        VERDICT_DROP    = 2'd1,
        VERDICT_RELAY   = 2'd2,
        VERDICT_DELIVER = 2'd3
    } t_verdict;

    // drop cause codes
    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_DUP    = 2'd1,
        CAUSE_OLD    = 2'd2,
        CAUSE_SILENT = 2'd3
    } t_cause;

endpackage

`default_nettype wire

/* rtl/multipath_duplicate_filter.sv */
`default_nettype none

// Receive-side duplicate filter for frames that arrive over several paths.
// Each item is checked for size and node lookups, then flagged as an error,
// relayed, dropped or delivered; for local frames the flow's window of the
// WINDOW most recent sequence numbers, held in one single-port RAM (one
// slot per word), is scanned one slot per cycle and the minimum slot is
// overwritten on delivery. An error, relay or silent-drop item goes from
// acceptance straight to the push state; a local item passes through the
// scan, decide and push states, the single RAM port reading one slot per
// cycle during the scan and the decide state writing the window. The result
// sits in an output register, so the next item is taken while it waits.
// After reset the RAM is cleared one word per cycle, all
// 2**(max(1, clog2(FLOWS)) + clog2(WINDOW)) words (128 by default); input
// stall is held high during that pass, configuration writes are taken at any time.
module multipath_duplicate_filter #(
    parameter int WINDOW = 8,
    parameter int FLOWS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [mdf_pkg::FLOW_IN_W-1:0] i_flow_index,
    input  wire logic [mdf_pkg::SEQ_W-1:0]     i_seq,
    input  wire logic [mdf_pkg::SIZE_W-1:0]    i_payload_size,
    input  wire logic                          i_src_known,
    input  wire logic                          i_dst_known,
    input  wire logic                          i_dst_is_local,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_verdict,
    output logic [1:0]                         o_drop_cause,
    output logic                               o_newest,
    output logic [mdf_pkg::SIZE_W-1:0]         o_out_size
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FLOW_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int ADDR_W = FLOW_W + SLOT_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int FLOW_X = FLOW_W + mdf_pkg::FLOW_IN_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PUSH
    } t_state;

    t_state                      r_state;
    logic                        r_relay_silent;
    logic [ADDR_W-1:0]           r_clr_cnt;
    logic [FLOW_W-1:0]           r_flow;
    logic [mdf_pkg::SEQ_W-1:0]   r_seq;
    logic [mdf_pkg::SIZE_W-1:0]  r_size;
    logic [SLOT_W:0]             r_issue;
    logic                        r_pend;
    logic [SLOT_W-1:0]           r_pend_slot;
    logic                        r_dup;
    logic [mdf_pkg::SEQ_W-1:0]   r_min;
    logic [mdf_pkg::SEQ_W-1:0]   r_max;
    logic [SLOT_W-1:0]           r_min_idx;
    mdf_pkg::t_verdict           r_res_verdict;
    mdf_pkg::t_cause             r_res_cause;
    logic                        r_res_newest;
    logic [mdf_pkg::SIZE_W-1:0]  r_res_size;
    logic                        r_out_valid;
    mdf_pkg::t_verdict           r_out_verdict;
    mdf_pkg::t_cause             r_out_cause;
    logic                        r_out_newest;
    logic [mdf_pkg::SIZE_W-1:0]  r_out_size;

    logic [FLOW_X-1:0]           flow_wide;
    logic                        flow_ok;
    logic                        frame_bad;
    logic                        in_acc;
    logic                        out_free;
    logic                        issue_more;
    logic                        slot_first;
    logic                        slot_last;
    logic                        take_min;
    logic                        n_dup;
    logic [mdf_pkg::SEQ_W-1:0]   n_min;
    logic [mdf_pkg::SEQ_W-1:0]   n_max;
    logic [SLOT_W-1:0]           n_min_idx;
    logic                        n_deliver;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_addr;
    logic [mdf_pkg::SEQ_W-1:0]   mem_wdata;
    logic [mdf_pkg::SEQ_W-1:0]   mem_rdata;

    // input classification
    assign flow_wide = FLOW_X'(i_flow_index);
    assign flow_ok   = flow_wide < FLOW_X'(FLOWS);
    assign frame_bad = (i_payload_size <= mdf_pkg::FOOTER_BYTES) || !i_src_known
                       || !i_dst_known;
    assign o_stall   = (r_state != S_IDLE);
    assign in_acc    = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;

    // window scan: one slot arrives per cycle from the ram
    assign issue_more = r_issue < (SLOT_W + 1)'(WINDOW);
    assign slot_first = (r_pend_slot == '0);
    assign slot_last  = (r_pend_slot == SLOT_W'(WINDOW - 1));
    // last slot wins ties for the minimum, others need a strictly smaller value
    assign take_min   = slot_first || (slot_last ? (mem_rdata <= r_min)
                                                 : (mem_rdata < r_min));
    assign n_dup      = r_dup || (mem_rdata == r_seq);
    assign n_min      = take_min ? mem_rdata : r_min;
    assign n_min_idx  = take_min ? r_pend_slot : r_min_idx;
    assign n_max      = (slot_first || (mem_rdata > r_max)) ? mem_rdata : r_max;

    // decision on the collected window summary
    assign n_deliver  = !r_dup && !(r_seq < r_min);

    // ram port mux
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = r_seq;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_cnt;
                mem_wdata = '0;
            end
            S_SCAN: begin
                mem_addr = {r_flow, r_issue[SLOT_W-1:0]};
            end
            S_DECIDE: begin
                mem_we   = n_deliver;
                mem_addr = {r_flow, r_min_idx};
            end
            S_IDLE, S_PUSH: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    mdf_ram #(
        .WIDTH (mdf_pkg::SEQ_W),
        .DEPTH (DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // sequencer, scan registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_relay_silent <= 1'b0;
            r_clr_cnt      <= '0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_relay_silent <= i_cfg_wdata;
            end

            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            r_pend      <= (r_state == S_SCAN) && issue_more;
            r_pend_slot <= r_issue[SLOT_W-1:0];

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (&r_clr_cnt) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_flow       <= flow_wide[FLOW_W-1:0];
                        r_seq        <= i_seq;
                        r_size       <= i_payload_size;
                        r_res_size   <= i_payload_size;
                        r_res_newest <= 1'b0;
                        r_res_cause  <= mdf_pkg::CAUSE_NONE;
                        r_issue      <= '0;
                        r_dup        <= 1'b0;
                        priority if (frame_bad) begin
                            r_res_verdict <= mdf_pkg::VERDICT_ERROR;
                            r_state       <= S_PUSH;
                        end else if (!i_dst_is_local && r_relay_silent) begin
                            r_res_verdict <= mdf_pkg::VERDICT_DROP;
                            r_res_cause   <= mdf_pkg::CAUSE_SILENT;
                            r_state       <= S_PUSH;
                        end else if (!i_dst_is_local) begin
                            r_res_verdict <= mdf_pkg::VERDICT_RELAY;
                            r_state       <= S_PUSH;
                        end else if (!flow_ok) begin
                            r_res_verdict <= mdf_pkg::VERDICT_ERROR;
                            r_state       <= S_PUSH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (issue_more) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (r_pend) begin
                        r_dup     <= n_dup;
                        r_min     <= n_min;
                        r_min_idx <= n_min_idx;
                        r_max     <= n_max;
                        if (slot_last) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    priority if (r_dup) begin
                        r_res_verdict <= mdf_pkg::VERDICT_DROP;
                        r_res_cause   <= mdf_pkg::CAUSE_DUP;
                    end else if (!n_deliver) begin
                        r_res_verdict <= mdf_pkg::VERDICT_DROP;
                        r_res_cause   <= mdf_pkg::CAUSE_OLD;
                    end else begin
                        r_res_verdict <= mdf_pkg::VERDICT_DELIVER;
                        r_res_newest  <= r_seq > r_max;
                        r_res_size    <= r_size - mdf_pkg::FOOTER_BYTES;
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out_verdict <= r_res_verdict;
                        r_out_cause   <= r_res_cause;
                        r_out_newest  <= r_res_newest;
                        r_out_size    <= r_res_size;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_verdict    = r_out_verdict;
    assign o_drop_cause = r_out_cause;
    assign o_newest     = r_out_newest;
    assign o_out_size   = r_out_size;

    // drop cause only accompanies a drop verdict
    a_cause_only_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_verdict == mdf_pkg::VERDICT_DROP)
                        || (r_out_cause == mdf_pkg::CAUSE_NONE))
        else $error("drop cause set on a non-drop item");

    // newest flag only on delivery
    a_newest_only_on_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_newest) |-> (r_out_verdict == mdf_pkg::VERDICT_DELIVER))
        else $error("newest flag set on a non-delivered item");

    // a window write never lands in a padding slot
    a_slot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && mem_we) |-> (r_min_idx <= SLOT_W'(WINDOW - 1)))
        else $error("window write outside the flow's slots");

    // decision follows the last slot of the scan
    a_decide_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> ($past(r_pend) && $past(r_state) == S_SCAN))
        else $error("decision taken before the window scan finished");

endmodule

`default_nettype wire

/* rtl/mdf_ram.sv */
`default_nettype none

module mdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
